// ===== sv/fscr_pkg.sv =====
// ----------------------------------------------------------------------------
// fscr_pkg: shared definitions for the framed speed command receiver
// Frame constants, status codes, the result record and the CRC-8 byte step.
// ----------------------------------------------------------------------------
package fscr_pkg;

    localparam logic [7:0] HEADER_BYTE0 = 8'h55;
    localparam logic [7:0] HEADER_BYTE1 = 8'hAA;
    localparam logic [7:0] CRC_POLY     = 8'h8C;
    localparam logic [7:0] MAX_PAYLOAD  = 8'd12;
    localparam int         STORE_DEPTH  = 5;
    localparam int         STORE_IDX_W  = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_CRC = 2'd1,
        ST_BAD_LEN = 2'd2
    } status_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [7:0]         control_flag;
    } fscr_result_t;

    // reflected CRC-8, one byte
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    localparam logic [7:0] HEADER_CRC = crc_fold(crc_fold(8'h00, HEADER_BYTE0), HEADER_BYTE1);

endpackage

// ===== sv/fscr_byte_if.sv =====
// ----------------------------------------------------------------------------
// fscr_byte_if: received byte channel
// Valid/ready channel carrying one serial byte per beat.
// ----------------------------------------------------------------------------
interface fscr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/fscr_result_if.sv =====
// ----------------------------------------------------------------------------
// fscr_result_if: frame result channel
// Valid/ready channel carrying status, wheel speeds and control flag.
// ----------------------------------------------------------------------------
interface fscr_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [7:0]         control_flag;

    modport source (output valid, output status, output left_speed,
                    output right_speed, output control_flag, input ready);
    modport sink   (input valid, input status, input left_speed,
                    input right_speed, input control_flag, output ready);
endinterface

// ===== sv/fscr_in_stage.sv =====
// ----------------------------------------------------------------------------
// fscr_in_stage: input byte register
// Holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module fscr_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    fscr_byte_if.sink  rx,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic [7:0] data_reg;

    assign rx.ready   = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            data_reg <= rx.rx_byte;
        end
    end

endmodule

// ===== sv/fscr_parser.sv =====
// ----------------------------------------------------------------------------
// fscr_parser: frame parser state and CRC check
// Advances header hunt, length, payload, CRC and tail phases one byte a beat.
// ----------------------------------------------------------------------------
module fscr_parser #(
    parameter logic [7:0] MAX_PAYLOAD = fscr_pkg::MAX_PAYLOAD
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            byte_data,
    output logic                  res_valid,
    output fscr_pkg::fscr_result_t result
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN     = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CRC     = 3'd3,
        PH_TAIL    = 3'd4
    } phase_t;

    phase_t     phase_reg,  phase_next;
    logic [7:0] prev_reg,   prev_next;
    logic [7:0] len_reg,    len_next;
    logic [7:0] count_reg,  count_next;
    logic       tail_reg,   tail_next;
    logic [7:0] crc_reg,    crc_next;
    logic [7:0] store_reg  [fscr_pkg::STORE_DEPTH];
    logic [7:0] store_next [fscr_pkg::STORE_DEPTH];

    logic [7:0] crc_step;
    logic [7:0] count_inc;

    assign crc_step  = fscr_pkg::crc_fold(crc_reg, byte_data);
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        len_next   = len_reg;
        count_next = count_reg;
        tail_next  = tail_reg;
        crc_next   = crc_reg;
        store_next = store_reg;
        res_valid  = 1'b0;
        result     = '0;

        unique case (phase_reg)
            PH_LEN:
            begin
                if (byte_data == 8'd0 || byte_data > MAX_PAYLOAD)
                begin
                    res_valid     = 1'b1;
                    result.status = fscr_pkg::ST_BAD_LEN;
                end
                else
                begin
                    len_next   = byte_data;
                    count_next = 8'd0;
                    crc_next   = crc_step;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (count_reg < 8'(fscr_pkg::STORE_DEPTH))
                begin
                    store_next[count_reg[fscr_pkg::STORE_IDX_W-1:0]] = byte_data;
                end
                crc_next   = crc_step;
                count_next = count_inc;
                if (count_inc >= len_reg)
                begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (byte_data != crc_reg)
                begin
                    res_valid     = 1'b1;
                    result.status = fscr_pkg::ST_BAD_CRC;
                end
                else
                begin
                    tail_next  = 1'b0;
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                if (!tail_reg)
                begin
                    tail_next = 1'b1;
                end
                else
                begin
                    res_valid           = 1'b1;
                    result.status       = fscr_pkg::ST_OK;
                    result.left_speed   = {store_reg[1], store_reg[0]};
                    result.right_speed  = {store_reg[3], store_reg[2]};
                    result.control_flag = store_reg[4];
                end
            end
            default:
            begin
                if (byte_data == fscr_pkg::HEADER_BYTE1)
                begin
                    if (prev_reg == fscr_pkg::HEADER_BYTE0)
                    begin
                        crc_next   = fscr_pkg::HEADER_CRC;
                        len_next   = 8'd0;
                        count_next = 8'd0;
                        tail_next  = 1'b0;
                        phase_next = PH_LEN;
                    end
                end
                else
                begin
                    prev_next = byte_data;
                end
            end
        endcase

        if (res_valid)
        begin
            phase_next = PH_HUNT;
            prev_next  = 8'd0;
            len_next   = 8'd0;
            count_next = 8'd0;
            tail_next  = 1'b0;
            crc_next   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            prev_reg  <= 8'd0;
            len_reg   <= 8'd0;
            count_reg <= 8'd0;
            tail_reg  <= 1'b0;
            crc_reg   <= 8'd0;
            for (int i = 0; i < fscr_pkg::STORE_DEPTH; i++)
            begin
                store_reg[i] <= 8'd0;
            end
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            tail_reg  <= tail_next;
            crc_reg   <= crc_next;
            store_reg <= store_next;
        end
    end

endmodule

// ===== sv/fscr_out_stage.sv =====
// ----------------------------------------------------------------------------
// fscr_out_stage: result register
// Holds one finished result until the consumer takes the beat.
// ----------------------------------------------------------------------------
module fscr_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  fscr_pkg::fscr_result_t result,
    output logic                  can_accept,
    fscr_result_if.source         res
);

    logic                   valid_reg;
    fscr_pkg::fscr_result_t data_reg;

    assign can_accept       = !valid_reg || res.ready;
    assign res.valid        = valid_reg;
    assign res.status       = data_reg.status;
    assign res.left_speed   = data_reg.left_speed;
    assign res.right_speed  = data_reg.right_speed;
    assign res.control_flag = data_reg.control_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

// ===== sv/framed_speed_command_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// framed_speed_command_receiver_unit: serial speed command frame receiver
// Parses 55 AA len payload crc t0 t1 frames and reports wheel speeds.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  rx       in   rx_byte[7:0]
//  res      out  status[1:0], left_speed[15:0], right_speed[15:0], control_flag[7:0]
//
//  One byte per cycle sustained while rx stays valid and res is not stalled; a byte
//  goes input register -> parser -> result register when it ends a frame, good or bad.
//  Reset clears parser state and the five-byte payload store at once.
//  A stalled res blocks the parser only when a new result is due; rx keeps
//  flowing through the input register otherwise.
// ----------------------------------------------------------------------------
module framed_speed_command_receiver_unit #(
    parameter logic [7:0] MAX_PAYLOAD = fscr_pkg::MAX_PAYLOAD
) (
    input  logic          clk,
    input  logic          rst_n,
    fscr_byte_if.sink     rx,
    fscr_result_if.source res
);

    logic                   byte_valid;
    logic [7:0]             byte_data;
    logic                   can_accept;
    logic                   step;
    logic                   res_valid;
    fscr_pkg::fscr_result_t result;

    assign step = byte_valid && (can_accept || !res_valid);

    fscr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    fscr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .result    (result)
    );

    fscr_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step && res_valid),
        .result     (result),
        .can_accept (can_accept),
        .res        (res)
    );

`ifndef NO_ASSERTIONS
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !step |=> byte_valid && $stable(byte_data))
        else $error("input byte lost while parser stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status != fscr_pkg::ST_OK |->
            res.left_speed == 16'sd0 && res.right_speed == 16'sd0 &&
            res.control_flag == 8'd0)
        else $error("error result carries data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.status != 2'd3)
        else $error("undefined status code");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.status))
        else $error("pending result overwritten");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: framed speed command receiver testbench
// Streams serial bytes (directed frames, then random frames, bad lengths, bad
// checksums, truncated frames and noise) into the receiver. It tracks the
// frame parser alongside the block and checks every reported frame field by
// field. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [7:0] TAIL_CR = 8'h0D;
    localparam logic [7:0] TAIL_LF = 8'h0A;
    localparam int RANDOM_BYTES = 1800;

    typedef enum logic [2:0] {
        HUNT_HEADER,
        READ_LEN,
        READ_PAYLOAD,
        CHECK_CRC,
        SKIP_TAIL
    } parse_phase_t;

    logic clk;
    logic rst_n;

    fscr_byte_if   rx_ch ();
    fscr_result_if res_ch ();

    framed_speed_command_receiver_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    // parser shadow state
    parse_phase_t parse_phase = HUNT_HEADER;
    logic [7:0]   last_byte   = 8'h00;
    logic [7:0]   frame_len   = 8'h00;
    logic [7:0]   frame_cnt   = 8'h00;
    logic         tail_seen   = 1'b0;
    logic [7:0]   frame_crc   = 8'h00;
    logic [7:0]   speed_store [fscr_pkg::STORE_DEPTH] = '{default: 8'h00};

    logic [7:0]             rx_pending [$];
    fscr_pkg::fscr_result_t due_reports [$];
    fscr_pkg::fscr_result_t want;

    int unsigned send_gap_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned bytes_queued   = 0;
    int unsigned mismatches     = 0;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [7:0] crc8_maxim_step(input logic [7:0] crc,
                                                   input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ fscr_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic track_frame_byte(input logic [7:0] b);
        fscr_pkg::fscr_result_t r;
        logic                   done;
        r    = '0;
        done = 1'b0;
        case (parse_phase)
            READ_LEN:
            begin
                if (b == 8'h00 || b > fscr_pkg::MAX_PAYLOAD)
                begin
                    r.status = fscr_pkg::ST_BAD_LEN;
                    done     = 1'b1;
                end
                else
                begin
                    frame_len   = b;
                    frame_cnt   = 8'h00;
                    frame_crc   = crc8_maxim_step(frame_crc, b);
                    parse_phase = READ_PAYLOAD;
                end
            end
            READ_PAYLOAD:
            begin
                if (frame_cnt < fscr_pkg::STORE_DEPTH)
                begin
                    speed_store[frame_cnt] = b;
                end
                frame_crc = crc8_maxim_step(frame_crc, b);
                frame_cnt = frame_cnt + 8'd1;
                if (frame_cnt >= frame_len)
                begin
                    parse_phase = CHECK_CRC;
                end
            end
            CHECK_CRC:
            begin
                if (b != frame_crc)
                begin
                    r.status = fscr_pkg::ST_BAD_CRC;
                    done     = 1'b1;
                end
                else
                begin
                    tail_seen   = 1'b0;
                    parse_phase = SKIP_TAIL;
                end
            end
            SKIP_TAIL:
            begin
                if (!tail_seen)
                begin
                    tail_seen = 1'b1;
                end
                else
                begin
                    r.status       = fscr_pkg::ST_OK;
                    r.left_speed   = {speed_store[1], speed_store[0]};
                    r.right_speed  = {speed_store[3], speed_store[2]};
                    r.control_flag = speed_store[4];
                    done           = 1'b1;
                end
            end
            default:
            begin
                // AA never overwrites the remembered byte
                if (b == fscr_pkg::HEADER_BYTE1)
                begin
                    if (last_byte == fscr_pkg::HEADER_BYTE0)
                    begin
                        frame_crc   = crc8_maxim_step(
                                          crc8_maxim_step(8'h00, fscr_pkg::HEADER_BYTE0),
                                          fscr_pkg::HEADER_BYTE1);
                        frame_len   = 8'h00;
                        frame_cnt   = 8'h00;
                        tail_seen   = 1'b0;
                        parse_phase = READ_LEN;
                    end
                end
                else
                begin
                    last_byte = b;
                end
            end
        endcase
        if (done)
        begin
            due_reports.push_back(r);
            parse_phase = HUNT_HEADER;
            last_byte   = 8'h00;
            frame_len   = 8'h00;
            frame_cnt   = 8'h00;
            tail_seen   = 1'b0;
            frame_crc   = 8'h00;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_frame(input logic [7:0] body[$], input logic [7:0] crc_flip);
        logic [7:0] crc;
        crc = crc8_maxim_step(crc8_maxim_step(8'h00, fscr_pkg::HEADER_BYTE0),
                              fscr_pkg::HEADER_BYTE1);
        crc = crc8_maxim_step(crc, 8'(body.size()));
        queue_byte(fscr_pkg::HEADER_BYTE0);
        queue_byte(fscr_pkg::HEADER_BYTE1);
        queue_byte(8'(body.size()));
        foreach (body[i])
        begin
            crc = crc8_maxim_step(crc, body[i]);
            queue_byte(body[i]);
        end
        queue_byte(crc ^ crc_flip);
        if ($urandom_range(1) == 0)
        begin
            queue_byte(TAIL_CR);
            queue_byte(TAIL_LF);
        end
        else
        begin
            queue_byte(8'($urandom));
            queue_byte(8'($urandom));
        end
    endtask

    task automatic queue_bad_length(input logic [7:0] len);
        queue_byte(fscr_pkg::HEADER_BYTE0);
        queue_byte(fscr_pkg::HEADER_BYTE1);
        queue_byte(len);
    endtask

    task automatic drain_bytes();
        while (rx_pending.size() != 0 || rx_ch.valid)
        begin
            @(negedge clk);
        end
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'h00;
        end
        else if (!rx_ch.valid || rx_ch.ready)
        begin
            if (rx_pending.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                rx_ch.valid   <= 1'b1;
                rx_ch.rx_byte <= rx_pending.pop_front();
            end
            else
            begin
                rx_ch.valid <= 1'b0;
            end
        end
    end

    // result sink
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // byte tracking and result checks
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                track_frame_byte(rx_ch.rx_byte);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (due_reports.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d left %0d right %0d ctrl %0d",
                             $realtime, res_ch.status, res_ch.left_speed,
                             res_ch.right_speed, res_ch.control_flag);
                    mismatches++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (res_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, res_ch.status);
                        mismatches++;
                    end
                    if (res_ch.left_speed !== want.left_speed)
                    begin
                        $display("%0t: left_speed expected %0d actual %0d",
                                 $realtime, want.left_speed, res_ch.left_speed);
                        mismatches++;
                    end
                    if (res_ch.right_speed !== want.right_speed)
                    begin
                        $display("%0t: right_speed expected %0d actual %0d",
                                 $realtime, want.right_speed, res_ch.right_speed);
                        mismatches++;
                    end
                    if (res_ch.control_flag !== want.control_flag)
                    begin
                        $display("%0t: control_flag expected %0d actual %0d",
                                 $realtime, want.control_flag, res_ch.control_flag);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [7:0]  body[$];
        int unsigned kind;
        int unsigned len;
        int unsigned phase_end;

        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        res_ch.ready  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, short frame, bad lengths, bad checksum, AA noise
        body = '{8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF};
        queue_frame(body, 8'h00);
        body = '{8'h5A};
        queue_frame(body, 8'h00);
        queue_bad_length(8'h00);
        queue_bad_length(fscr_pkg::MAX_PAYLOAD + 8'd1);
        queue_bad_length(8'hFF);
        body = '{8'h01};
        queue_frame(body, 8'hFF);
        queue_byte(8'h33);
        queue_byte(fscr_pkg::HEADER_BYTE1);
        body = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h11, 8'h22, 8'h33,
                 8'h44, 8'h55, 8'h66, 8'hAA};
        queue_frame(body, 8'h00);
        drain_bytes();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_gap_pct = 52; sink_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  sink_stall_pct = 52; end
                default: begin send_gap_pct = 37; sink_stall_pct = 37; end
            endcase
            phase_end = bytes_queued + RANDOM_BYTES / 4;
            while (bytes_queued < phase_end)
            begin
                kind = $urandom_range(99);
                len  = ($urandom_range(3) == 0) ? $urandom_range(6, fscr_pkg::MAX_PAYLOAD)
                                                : $urandom_range(1, 5);
                body.delete();
                for (int i = 0; i < len; i++)
                begin
                    body.push_back(8'($urandom));
                end
                if (kind < 66)
                begin
                    queue_frame(body, 8'h00);
                end
                else if (kind < 76)
                begin
                    queue_frame(body, 8'(1 << $urandom_range(7)));
                end
                else if (kind < 84)
                begin
                    queue_bad_length(($urandom_range(1) == 0) ? 8'h00
                                     : 8'($urandom_range(fscr_pkg::MAX_PAYLOAD + 1, 255)));
                end
                else if (kind < 92)
                begin
                    for (int i = $urandom_range(1, 6); i > 0; i--)
                    begin
                        case ($urandom_range(3))
                            0: queue_byte(fscr_pkg::HEADER_BYTE0);
                            1: queue_byte(fscr_pkg::HEADER_BYTE1);
                            default: queue_byte(8'($urandom));
                        endcase
                    end
                end
                else
                begin
                    // frame cut short; the next bytes complete it
                    queue_byte(fscr_pkg::HEADER_BYTE0);
                    queue_byte(fscr_pkg::HEADER_BYTE1);
                    queue_byte(8'(len));
                    for (int i = $urandom_range(len - 1); i > 0; i--)
                    begin
                        queue_byte(8'($urandom));
                    end
                end
            end
            drain_bytes();
        end

        while (due_reports.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);

        if (mismatches == 0 && due_reports.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
